### rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types and constants for the decoder front end, the point queue and
// the code unit emitter.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned POINT_W = 21;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MIN_W   = 17;

    localparam logic [POINT_W-1:0] PLANE1_BASE   = 21'h010000;
    localparam logic [POINT_W-1:0] POINT_LIMIT   = 21'h110000;
    localparam logic [POINT_W-1:0] SURR_LO       = 21'h00d800;
    localparam logic [POINT_W-1:0] SURR_HI       = 21'h00dfff;
    localparam logic [POINT_W-1:0] NONCHAR_LO    = 21'h00fdd0;
    localparam logic [POINT_W-1:0] NONCHAR_HI    = 21'h00fdef;

    localparam logic [MIN_W-1:0]   MIN_TWO_BYTE   = 17'h00080;
    localparam logic [MIN_W-1:0]   MIN_THREE_BYTE = 17'h00800;
    localparam logic [MIN_W-1:0]   MIN_FOUR_BYTE  = 17'h10000;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // One finished code point handed from the front end to the queue.
    typedef struct packed {
        logic               push;
        logic [POINT_W-1:0] point;
    } t_point_push;

    // Head of the queue as seen by the emitter.
    typedef struct packed {
        logic               valid;
        logic [POINT_W-1:0] point;
    } t_point_head;

endpackage : u8u16_pkg
`default_nettype wire

### rtl/u8u16_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle while the queue is not full, gathers multi-byte
// sequences and pushes each accepted code point into the point queue.
// ---------------------------------------------------------------------------
module u8u16_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [u8u16_pkg::BYTE_W-1:0] i_byte_in,
    input  wire logic                        i_full,
    output logic                             o_stall,
    output u8u16_pkg::t_point_push           o_push
);
    import u8u16_pkg::*;

    logic [1:0]         r_pending;
    logic [POINT_W-1:0] r_partial;
    logic [MIN_W-1:0]   r_min;
    logic [1:0]         n_pending;
    logic [POINT_W-1:0] n_partial;
    logic [MIN_W-1:0]   n_min;

    logic               accept;
    logic [POINT_W-1:0] joined;
    logic               rejected;
    logic               push;
    logic [POINT_W-1:0] push_point;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    assign joined = {r_partial[POINT_W-7:0], i_byte_in[5:0]};

    always_comb begin
        rejected = 1'b0;
        if (joined >= POINT_LIMIT) rejected = 1'b1;
        if (joined < {{(POINT_W-MIN_W){1'b0}}, r_min}) rejected = 1'b1;
        if (joined >= SURR_LO && joined <= SURR_HI) rejected = 1'b1;
        if (joined >= NONCHAR_LO && joined <= NONCHAR_HI) rejected = 1'b1;
        if (joined[15:1] == 15'h7fff) rejected = 1'b1;
    end

    always_comb begin
        n_pending  = r_pending;
        n_partial  = r_partial;
        n_min      = r_min;
        push       = 1'b0;
        push_point = joined;
        if (r_pending != 2'd0) begin
            if (i_byte_in[7:6] != 2'b10) begin
                // Broken sequence: the byte is swallowed.
                n_pending = 2'd0;
                n_partial = '0;
                n_min     = '0;
            end else if (r_pending == 2'd1) begin
                n_pending = 2'd0;
                n_partial = '0;
                n_min     = '0;
                push      = !rejected;
            end else begin
                n_pending = r_pending - 2'd1;
                n_partial = joined;
            end
        end else begin
            if (i_byte_in[7:5] == 3'b110) begin
                n_partial = {{(POINT_W-5){1'b0}}, i_byte_in[4:0]};
                n_pending = 2'd1;
                n_min     = MIN_TWO_BYTE;
            end else if (i_byte_in[7:4] == 4'b1110) begin
                n_partial = {{(POINT_W-4){1'b0}}, i_byte_in[3:0]};
                n_pending = 2'd2;
                n_min     = MIN_THREE_BYTE;
            end else if (i_byte_in[7:3] == 5'b11110) begin
                n_partial = {{(POINT_W-3){1'b0}}, i_byte_in[2:0]};
                n_pending = 2'd3;
                n_min     = MIN_FOUR_BYTE;
            end else begin
                push       = 1'b1;
                push_point = {{(POINT_W-BYTE_W){1'b0}}, i_byte_in};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_min     <= '0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_min     <= n_min;
        end
    end

    assign o_push.push  = accept && push;
    assign o_push.point = push_point;

`ifndef ASSERT_OFF
    // An open sequence always knows its overlong bound.
    a_open_has_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) |-> (r_min != '0))
        else $error("open sequence without minimum point");
`endif

endmodule : u8u16_front
`default_nettype wire

### rtl/u8u16_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Code point queue
// Small FIFO of finished code points between the front end and the emitter.
// ---------------------------------------------------------------------------
module u8u16_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire u8u16_pkg::t_point_push i_push,
    input  wire logic                   i_pop,
    output logic                        o_full,
    output u8u16_pkg::t_point_head      o_head
);
    import u8u16_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [POINT_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.valid = (r_count != '0);
    assign o_head.point = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    // The front end never pushes into a full queue, so nothing is lost.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("push into full queue");

    // Occupancy tracks the pointers.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT)
        && ((r_count == '0 || r_count == FULL_CNT) == (r_wr_ptr == r_rd_ptr)))
        else $error("queue count and pointers disagree");
`endif

endmodule : u8u16_queue
`default_nettype wire

### rtl/u8u16_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-16 code unit emitter
// Pops code points from the queue and drives the output register, splitting
// supplementary points into a surrogate pair, high half first.
// ---------------------------------------------------------------------------
module u8u16_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire u8u16_pkg::t_point_head      i_head,
    output logic                             o_pop,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic [u8u16_pkg::UNIT_W-1:0]     o_code_unit,
    output logic                             o_last
);
    import u8u16_pkg::*;

    logic              r_valid;
    logic [UNIT_W-1:0] r_unit;
    logic              r_last;
    logic              r_low_pend;
    logic [UNIT_W-1:0] r_low_unit;

    logic               slot_free;
    logic               is_pair;
    logic [POINT_W-1:0] offset;

    assign slot_free = !r_valid || !i_stall;
    assign is_pair   = (i_head.point >= PLANE1_BASE);
    assign offset    = i_head.point - PLANE1_BASE;
    assign o_pop     = slot_free && !r_low_pend && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_low_pend <= 1'b0;
        end else if (slot_free) begin
            if (r_low_pend) begin
                r_valid    <= 1'b1;
                r_unit     <= r_low_unit;
                r_last     <= 1'b1;
                r_low_pend <= 1'b0;
            end else if (i_head.valid) begin
                r_valid <= 1'b1;
                if (is_pair) begin
                    r_unit     <= {HIGH_SURR_TAG, offset[19:10]};
                    r_last     <= 1'b0;
                    r_low_unit <= {LOW_SURR_TAG, offset[9:0]};
                    r_low_pend <= 1'b1;
                end else begin
                    r_unit <= i_head.point[UNIT_W-1:0];
                    r_last <= 1'b1;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_unit;
    assign o_last      = r_last;

`ifndef ASSERT_OFF
    // While the low half waits, the output shows the high half of its pair.
    a_high_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_pend |-> (r_valid && !r_last && r_unit[15:10] == HIGH_SURR_TAG))
        else $error("low surrogate pending without high surrogate shown");
`endif

endmodule : u8u16_back
`default_nettype wire

### rtl/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Converts a byte stream of UTF-8 into UTF-16 code units.
// ---------------------------------------------------------------------------
// The decoder accepts one UTF-8 byte per cycle while the queue has room and
// delivers UTF-16 code units with o_last set on the final unit caused by
// each byte. A front end gathers multi-byte sequences and checks the
// finished code point; points that are overlong, surrogates, beyond
// 0x10FFFF or noncharacters are dropped, as are bytes that break an open
// sequence, while stray bytes outside a sequence pass through as code units
// of the same value. Finished points go through a small queue (QUEUE_DEPTH
// entries) to an emitter that owns the output register. A byte enters every
// cycle as long as the queue has room; a BMP point leaves as one code unit
// and a supplementary point as the two units of its surrogate pair. Every
// supplementary point needs four bytes, so with a ready receiver the output
// port keeps up and the sustained rate is one byte per cycle; only receiver
// stalls can fill the queue. The completing byte is written into the queue,
// and its first code unit then goes into the emitter's output register.
// o_stall rises only while the queue is full.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [u8u16_pkg::BYTE_W-1:0] i_byte_in,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]      o_code_unit,
    output logic                              o_last
);
    import u8u16_pkg::*;

    t_point_push front_push;
    t_point_head queue_head;
    logic        queue_full;
    logic        back_pop;

    // Sequence assembly and code point checks.
    u8u16_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_byte_in (i_byte_in),
        .i_full    (queue_full),
        .o_stall   (o_stall),
        .o_push    (front_push)
    );

    // Decouples byte intake from surrogate pair expansion.
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pop   (back_pop),
        .o_full  (queue_full),
        .o_head  (queue_head)
    );

    // Output register and surrogate pair split.
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (queue_head),
        .o_pop       (back_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_code_unit (o_code_unit),
        .o_last      (o_last)
    );

endmodule : utf8_to_utf16_decoder
`default_nettype wire

### dv/utf8_to_utf16_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Feeds UTF-8 bytes through the valid/stall input and checks every UTF-16
// code unit against a cycle-free decoder kept in step with the accepted
// bytes. Directed cases cover stray and ASCII bytes, good sequences of each
// length, dropped code points and a broken sequence; random traffic then
// mixes well-formed sequences with broken ones and noise under three
// stall mixes.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder_test;

    import u8u16_pkg::*;

    // Lead and continuation byte tags of UTF-8.
    localparam logic [2:0] LEAD_TWO_TAG   = 3'b110;
    localparam logic [3:0] LEAD_THREE_TAG = 4'b1110;
    localparam logic [4:0] LEAD_FOUR_TAG  = 5'b11110;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    // Cycles without any accepted item, while work is outstanding, that end
    // the run as hung, set far above the wait of any correct run.
    localparam int unsigned HANG_LIMIT   = 2000;
    // Cycles to watch after the last result for anything extra.
    localparam int unsigned TAIL_CYCLES  = 12;

    typedef struct packed {
        logic [UNIT_W-1:0] value;
        logic              is_last;
    } t_code_unit;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_byte_in = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [UNIT_W-1:0]   o_code_unit;
    logic                o_last;

    // Decoder state mirrored from the accepted byte stream.
    logic [1:0]          cont_left = '0;
    logic [POINT_W-1:0]  gathered_point = '0;
    logic [MIN_W-1:0]    lowest_point = '0;

    // Code units still owed by the block, oldest first.
    t_code_unit          owed_units[$];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         bytes_sent = 0;
    int unsigned         units_checked = 0;
    int unsigned         surrogate_units = 0;
    int unsigned         quiet_cycles = 0;

    utf8_to_utf16_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_in   (i_byte_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_unit (o_code_unit),
        .o_last      (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver holds off at random, decided anew on every falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // A finished point is unusable when it is out of range, overlong for its
    // sequence length, a surrogate or one of the Unicode noncharacters.
    function automatic logic point_is_unusable(input logic [POINT_W-1:0] cp,
                                               input logic [MIN_W-1:0] lowest);
        return (cp >= POINT_LIMIT) || (cp < POINT_W'(lowest)) ||
               (cp >= SURR_LO && cp <= SURR_HI) ||
               (cp >= NONCHAR_LO && cp <= NONCHAR_HI) ||
               (cp[15:1] == 15'h7fff);
    endfunction

    // Advances the mirrored decoder by one accepted byte and queues the code
    // units that the byte completes.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [POINT_W-1:0] cp;
        logic [POINT_W-1:0] offset;
        if (cont_left != 0) begin
            if (b[7:6] != CONT_TAG) begin
                // The sequence is abandoned and the intruding byte is eaten.
                cont_left = '0;
                gathered_point = '0;
                lowest_point = '0;
            end else begin
                cp = {gathered_point[POINT_W-7:0], b[5:0]};
                gathered_point = cp;
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    if (!point_is_unusable(cp, lowest_point)) begin
                        if (cp >= PLANE1_BASE) begin
                            offset = cp - PLANE1_BASE;
                            owed_units.push_back({HIGH_SURR_TAG, offset[19:10], 1'b0});
                            owed_units.push_back({LOW_SURR_TAG, offset[9:0], 1'b1});
                        end else begin
                            owed_units.push_back({cp[UNIT_W-1:0], 1'b1});
                        end
                    end
                    gathered_point = '0;
                    lowest_point = '0;
                end
            end
        end else if (b[7:5] == LEAD_TWO_TAG) begin
            gathered_point = POINT_W'(b[4:0]);
            cont_left = 2'd1;
            lowest_point = MIN_TWO_BYTE;
        end else if (b[7:4] == LEAD_THREE_TAG) begin
            gathered_point = POINT_W'(b[3:0]);
            cont_left = 2'd2;
            lowest_point = MIN_THREE_BYTE;
        end else if (b[7:3] == LEAD_FOUR_TAG) begin
            gathered_point = POINT_W'(b[2:0]);
            cont_left = 2'd3;
            lowest_point = MIN_FOUR_BYTE;
        end else begin
            // ASCII, stray continuation bytes and 0xF8..0xFF pass through.
            owed_units.push_back({8'h00, b, 1'b1});
        end
    endtask

    // Checks outputs and predicts from inputs on every rising edge. The
    // output is checked first: a byte taken at this edge cannot have caused
    // anything that is already on the output.
    always @(posedge i_clk) begin
        t_code_unit want;
        logic       took_any;
        if (i_rst_n) begin
            took_any = 1'b0;
            if (o_valid && !i_stall) begin
                took_any = 1'b1;
                units_checked++;
                if (o_code_unit[15:11] == HIGH_SURR_TAG[5:1]) begin
                    surrogate_units++;
                end
                if (owed_units.size() == 0) begin
                    report_mismatch($sformatf("unexpected code unit %04h last %0b",
                                              o_code_unit, o_last));
                end else begin
                    want = owed_units.pop_front();
                    if (o_code_unit !== want.value) begin
                        report_mismatch($sformatf("code unit %04h, expected %04h",
                                                  o_code_unit, want.value));
                    end
                    if (o_last !== want.is_last) begin
                        report_mismatch($sformatf("last %0b on unit %04h, expected %0b",
                                                  o_last, want.value, want.is_last));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                took_any = 1'b1;
                decode_byte(i_byte_in);
            end
            // Only count cycles in which something is outstanding, so that
            // sender gaps on an empty pipe do not look like a hang.
            if (took_any || (!i_valid && owed_units.size() == 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= HANG_LIMIT) begin
                    $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
                    $display("utf8_to_utf16_decoder_test failed");
                    $finish;
                end
            end
        end
    end

    // Presents one byte from a falling edge, holding it until it is taken,
    // and returns at the falling edge after acceptance with valid still high.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_byte_in = value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Encodes a point into a sequence of the given length, overlong or out
    // of range if the point asks for it, and sends it.
    task automatic send_point(input int unsigned len, input logic [POINT_W-1:0] cp);
        case (len)
            2: begin
                send_byte({LEAD_TWO_TAG, cp[10:6]});
                send_byte({CONT_TAG, cp[5:0]});
            end
            3: begin
                send_byte({LEAD_THREE_TAG, cp[15:12]});
                send_byte({CONT_TAG, cp[11:6]});
                send_byte({CONT_TAG, cp[5:0]});
            end
            default: begin
                send_byte({LEAD_FOUR_TAG, cp[20:18]});
                send_byte({CONT_TAG, cp[17:12]});
                send_byte({CONT_TAG, cp[11:6]});
                send_byte({CONT_TAG, cp[5:0]});
            end
        endcase
    endtask

    // Stops sending and waits on a falling edge until every owed unit is in.
    task automatic wait_for_results();
        i_valid = 1'b0;
        while (owed_units.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h80);
        send_byte(8'hff);
    endtask

    task automatic test_good_sequences();
        send_point(2, 21'h000080);
        send_point(3, 21'h0020ac);
        send_point(4, 21'h10fffd);
    endtask

    task automatic test_dropped_points();
        send_point(2, 21'h00007f);
        send_point(3, 21'h00d800);
        send_point(3, 21'h00fdd0);
        send_point(4, 21'h110000);
    endtask

    task automatic test_broken_sequence();
        send_byte(8'hc3);
        send_byte(8'h41);
    endtask

    // One random run: mostly well-formed sequences whose points lean toward
    // the edges of the rejection rules, plus broken sequences and noise.
    task automatic send_random_run();
        int unsigned        kind;
        int unsigned        pick;
        int unsigned        need;
        int unsigned        conts;
        logic [BYTE_W-1:0]  lead;
        logic [POINT_W-1:0] cp;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (kind < 12) begin
            send_byte(BYTE_W'($urandom_range(0, 8'h7f)));
        end else if (kind < 18) begin
            if (pick < 5) begin
                send_byte(BYTE_W'($urandom_range(8'h80, 8'hbf)));
            end else begin
                send_byte(BYTE_W'($urandom_range(8'hf8, 8'hff)));
            end
        end else if (kind < 36) begin
            cp = POINT_W'((pick == 0) ? $urandom_range(0, 'h7f)
                                      : $urandom_range('h80, 'h7ff));
            send_point(2, cp);
        end else if (kind < 60) begin
            case (pick)
                0: cp = POINT_W'($urandom_range(0, 'h7ff));
                1: cp = POINT_W'($urandom_range('hd800, 'hdfff));
                2: cp = POINT_W'($urandom_range('hfdd0, 'hfdef));
                3: cp = POINT_W'($urandom_range('hfffe, 'hffff));
                default: cp = POINT_W'($urandom_range('h800, 'hffff));
            endcase
            send_point(3, cp);
        end else if (kind < 84) begin
            case (pick)
                0: cp = POINT_W'($urandom_range(0, 'hffff));
                1: cp = POINT_W'($urandom_range('h110000, 'h1fffff));
                2: cp = {1'b0, 4'($urandom_range(1, 15)), 15'h7fff,
                         1'($urandom_range(0, 1))};
                default: cp = POINT_W'($urandom_range('h10000, 'h10ffff));
            endcase
            send_point(4, cp);
        end else if (kind < 94) begin
            // Lead byte, fewer continuation bytes than it needs, then any
            // byte that is not a continuation byte.
            lead = BYTE_W'($urandom_range(8'hc0, 8'hf7));
            need = (lead < 8'he0) ? 1 : (lead < 8'hf0) ? 2 : 3;
            conts = $urandom_range(0, need - 1);
            send_byte(lead);
            repeat (conts) begin
                send_byte({CONT_TAG, 6'($urandom_range(0, 63))});
            end
            pick = $urandom_range(0, 191);
            send_byte(BYTE_W'((pick < 128) ? pick : pick + 64));
        end else begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic(input int unsigned byte_count);
        int unsigned stop_at;
        stop_at = bytes_sent + byte_count;
        while (bytes_sent < stop_at) begin
            send_random_run();
        end
    endtask

    // Sends a few surrogate pairs back to back, then lets the output side
    // catch up completely before anything else is sent.
    task automatic test_drain_pause();
        repeat (4) begin
            send_point(4, POINT_W'($urandom_range('h10000, 'h10ffff)));
        end
        wait_for_results();
    endtask

    initial begin
        int unsigned directed_bytes;
        // Synchronous reset held from the start and released at a falling edge,
        // so that the first item lines up with driving.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // First mix: the sender rarely idles and the receiver often stalls,
        // which fills the block's queue and exercises o_stall.
        send_idle_pct = 22;
        recv_idle_pct = 68;
        test_single_bytes();
        test_good_sequences();
        test_dropped_points();
        test_broken_sequence();
        directed_bytes = bytes_sent;
        test_random_traffic(135);
        test_drain_pause();

        // Second mix: a sparse sender and a mostly ready receiver.
        send_idle_pct = 68;
        recv_idle_pct = 22;
        test_random_traffic(135);
        wait_for_results();

        // Last mix: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(135);
        wait_for_results();

        // Watch a little longer for any unit the block should not produce.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (owed_units.size() != 0) begin
            report_mismatch($sformatf("%0d code units never arrived", owed_units.size()));
        end

        $display("Run covered %0d bytes (%0d directed) under three stall mixes,",
                 bytes_sent, directed_bytes);
        $display("checking %0d code units, %0d of them surrogate halves, %0d mismatches.",
                 units_checked, surrogate_units, mismatch_count);
        if (mismatch_count == 0) begin
            $display("utf8_to_utf16_decoder_test passed");
        end else begin
            $display("utf8_to_utf16_decoder_test failed");
        end
        $finish;
    end

endmodule
